>>> hw/rtl/u2c_pkg.sv
package u2c_pkg;

   // Offset added to the timestamp so that it reads as unsigned and is a
   // whole number of seconds away from the signed value (2^47 + 672).
   localparam logic [48:0] MS_ROUND   = 49'd672;
   // Seconds offset applied after the ms division: brings the day quotient
   // straight to the shifted day count (epoch shift plus twelve 400-year eras).
   localparam logic [38:0] SEC_OFFSET = 39'd72897916444;

   localparam logic [23:0] DIV_MS_8   = 24'd125;
   localparam logic [23:0] DIV_DAY    = 24'd86400;
   localparam logic [23:0] DIV_ERA    = 24'd146097;
   localparam logic [23:0] DIV_4Y     = 24'd1460;
   localparam logic [23:0] DIV_100Y   = 24'd36524;
   localparam logic [23:0] DIV_YEAR   = 24'd365;
   localparam logic [23:0] DIV_CENT   = 24'd100;
   localparam logic [23:0] DIV_MONTH5 = 24'd153;
   localparam logic [23:0] DIV_HOUR   = 24'd3600;
   localparam logic [23:0] DIV_MIN    = 24'd60;
   localparam logic [23:0] DIV_WEEK   = 24'd7;

   localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
   localparam logic [14:0] YEAR_OFFSET  = 15'd4800;

   typedef struct packed {
      logic signed [13:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [2:0]         weekday;
      logic [16:0]        rem;
      logic [8:0]         ordinal;
      logic               leap;
      logic               leap_prev;
   } civil_type;

   // Restoring division by a constant, up to eight quotient bits per call.
   // quo holds the remaining dividend bits at [width-1] downwards; quotient
   // bits enter at bit 0. Returns {remainder, quo}.
   function automatic logic [63:0] div_steps(input logic [23:0] rem,
                                             input logic [39:0] quo,
                                             input logic [23:0] dvs,
                                             input int unsigned width,
                                             input int unsigned steps);
      logic [24:0] t;
      logic [23:0] r;
      logic [39:0] a;
      r = rem;
      a = quo;
      for (int i = 0; i < 8; i++) begin
         if (i < steps) begin
            t = {r, a[width-1]};
            if (t >= {1'b0, dvs}) begin
               t = t - {1'b0, dvs};
               a = {a[38:0], 1'b1};
            end else begin
               a = {a[38:0], 1'b0};
            end
            r = t[23:0];
         end
      end
      return {r, a};
   endfunction

endpackage

>>> hw/rtl/u2c_days_to_date.sv
module u2c_days_to_date
   import u2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [38:0] in_sec,
   output logic        out_valid,
   output civil_type   out_date
);

   function automatic logic [8:0] month_base(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // yy is the year within its 400-year cycle, 0..400
   function automatic logic leap_of(input logic [8:0] yy);
      return (yy[1:0] == 2'b00) && (yy != 9'd100) && (yy != 9'd200) && (yy != 9'd300);
   endfunction

   logic        v_ff [1:10];
   logic [16:0] dr_ff [1:3];
   logic [21:0] dq_ff [1:3];
   logic [16:0] rem_ff [4:9];
   logic [4:0]  era_ff [4:9];
   logic [2:0]  wd_ff [4:9];
   logic [17:0] doe_ff [4:7];
   logic [6:0]  q4y_ff;
   logic [2:0]  q100y_ff;
   logic        last_ff;
   logic [8:0]  yr_ff;
   logic [8:0]  ya_ff;
   logic [8:0]  yoe_ff [7:9];
   logic [8:0]  doy_ff [8:9];
   logic [3:0]  mp_ff;
   civil_type   date_ff;

   logic [63:0] d1_in, d2_in, d3_in, era_in, q4y_in, q100y_in, y6_in, y7_in, c8_in, m9_in;
   logic [2:0]  wd_in;
   logic [17:0] t_in;
   logic [17:0] doy_wide_in;
   logic [10:0] x_in;
   civil_type   date_in;

   always_comb begin
      d1_in = div_steps(24'(in_sec[38:22]), 40'(in_sec[21:0]), DIV_DAY, 22, 8);
      d2_in = div_steps(24'(dr_ff[1]), 40'(dq_ff[1]), DIV_DAY, 22, 8);
      d3_in = div_steps(24'(dr_ff[2]), 40'(dq_ff[2]), DIV_DAY, 22, 6);
      era_in = div_steps(24'(dq_ff[3][21:5]), 40'(dq_ff[3][4:0]), DIV_ERA, 5, 5);
   end

   // weekday from the shifted day count: octal digit sum gives it mod 7
   always_comb begin
      logic [23:0] zp;
      logic [5:0]  s;
      logic [3:0]  s2;
      logic [2:0]  m;
      logic [3:0]  w;
      zp = {2'b00, dq_ff[3]};
      s  = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 6'(zp[3*i +: 3]);
      end
      s2 = {1'b0, s[5:3]} + {1'b0, s[2:0]};
      if (s2 >= 4'd14) begin
         m = 3'(s2 - 4'd14);
      end else if (s2 >= 4'd7) begin
         m = 3'(s2 - 4'd7);
      end else begin
         m = s2[2:0];
      end
      w = {1'b0, m} + 4'd2;
      wd_in = (w >= 4'd7) ? 3'(w - 4'd7) : w[2:0];
   end

   always_comb begin
      q4y_in   = div_steps(24'(doe_ff[4][17:7]), 40'(doe_ff[4][6:0]), DIV_4Y, 7, 7);
      q100y_in = div_steps(24'(doe_ff[4][17:3]), 40'(doe_ff[4][2:0]), DIV_100Y, 3, 3);
      t_in     = doe_ff[5] - 18'(q4y_ff) + 18'(q100y_ff) - 18'(last_ff);
      y6_in    = div_steps(24'(t_in[17:9]), 40'(t_in[8:0]), DIV_YEAR, 9, 5);
      y7_in    = div_steps(24'(yr_ff), 40'(ya_ff), DIV_YEAR, 9, 4);
      c8_in    = div_steps(24'(yoe_ff[7][8:2]), 40'(yoe_ff[7][1:0]), DIV_CENT, 2, 2);
      doy_wide_in = doe_ff[7] - (18'(yoe_ff[7]) * 18'd365 + 18'(yoe_ff[7][8:2])
                    - 18'(c8_in[1:0]));
      x_in     = 11'(doy_ff[8]) * 11'd5 + 11'd2;
      m9_in    = div_steps(24'(x_in[10:4]), 40'(x_in[3:0]), DIV_MONTH5, 4, 4);
   end

   always_comb begin
      logic        jan_feb;
      logic [8:0]  yy;
      logic [8:0]  yy_prev;
      logic [14:0] y15;
      jan_feb = (mp_ff >= 4'd10);
      yy      = yoe_ff[9] + 9'(jan_feb);
      yy_prev = (yy == 9'd0) ? 9'd399 : yy - 9'd1;
      y15     = 15'(yoe_ff[9]) + 15'(era_ff[9]) * 15'd400 + 15'(jan_feb) - YEAR_OFFSET;
      date_in.year      = y15[13:0];
      date_in.month     = jan_feb ? mp_ff - 4'd9 : mp_ff + 4'd3;
      date_in.day       = 5'(doy_ff[9] - month_base(mp_ff) + 9'd1);
      date_in.weekday   = wd_ff[9];
      date_in.rem       = rem_ff[9];
      date_in.leap      = leap_of(yy);
      date_in.leap_prev = leap_of(yy_prev);
      date_in.ordinal   = jan_feb ? doy_ff[9] - 9'd305
                                  : doy_ff[9] + 9'd60 + 9'(leap_of(yy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 10; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[1] <= in_valid;
         for (int k = 2; k <= 10; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[1] <= d1_in[40 +: 17];
         dq_ff[1] <= d1_in[21:0];
         dr_ff[2] <= d2_in[40 +: 17];
         dq_ff[2] <= d2_in[21:0];
         dr_ff[3] <= d3_in[40 +: 17];
         dq_ff[3] <= d3_in[21:0];
         rem_ff[4] <= dr_ff[3];
         era_ff[4] <= era_in[4:0];
         wd_ff[4]  <= wd_in;
         doe_ff[4] <= era_in[40 +: 18];
         for (int k = 5; k <= 9; k++) begin
            rem_ff[k] <= rem_ff[k-1];
            era_ff[k] <= era_ff[k-1];
            wd_ff[k]  <= wd_ff[k-1];
         end
         for (int k = 5; k <= 7; k++) begin
            doe_ff[k] <= doe_ff[k-1];
         end
         q4y_ff   <= q4y_in[6:0];
         q100y_ff <= q100y_in[2:0];
         last_ff  <= (doe_ff[4] == ERA_LAST_DAY);
         yr_ff    <= y6_in[40 +: 9];
         ya_ff    <= y6_in[8:0];
         yoe_ff[7] <= y7_in[8:0];
         yoe_ff[8] <= yoe_ff[7];
         yoe_ff[9] <= yoe_ff[8];
         doy_ff[8] <= doy_wide_in[8:0];
         doy_ff[9] <= doy_ff[8];
         mp_ff    <= m9_in[3:0];
         date_ff  <= date_in;
      end
   end

   assign out_valid = v_ff[10];
   assign out_date  = date_ff;

endmodule

>>> hw/rtl/unix_time_to_civil_and_iso_week.sv
// Unix millisecond timestamp to local calendar date and time, plus the
// ISO-8601 week date of the UTC day.
// Request channel: req_valid / req_stall with req_unix_ms; a transfer takes
// place at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with the ten result fields; one
// response per request, in order.
// Time-zone offset in minutes is written through csr_write_enable and
// csr_write_data; the user must write it only while the block is idle, as
// the block does not enforce this. It shifts the local fields only.
// Throughput: one item per cycle while the response is not stalled; a
// 19-stage pipeline of restoring constant-divisor steps (ms to s, s to day,
// day to 400-year era, era to year, month, hour and minute) sets the depth.
// A stalled response freezes the whole pipeline and raises req_stall in the
// same cycle; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and sets the offset
// to zero.
module unix_time_to_civil_and_iso_week
   import u2c_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [47:0] req_unix_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [2:0]         rsp_weekday,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic signed [13:0] rsp_wk_year,
   output logic [5:0]         rsp_wk_num,
   output logic [2:0]         rsp_wk_day,
   input  logic               csr_write_enable,
   input  logic signed [10:0] csr_write_data
);

   logic signed [10:0] tz_ff;
   logic               adv;

   logic        ms_v_ff [0:5];
   logic [6:0]  ms_r_ff [0:5];
   logic [38:0] ms_q_ff [0:5];
   logic        sec_v_ff;
   logic [38:0] utc_sec_ff;
   logic [38:0] loc_sec_ff;

   logic        loc_v;
   civil_type   loc_date;
   civil_type   utc_date;

   logic               f1_v_ff;
   logic [4:0]         f1_hour_ff;
   logic [11:0]        f1_rhour_ff;
   logic signed [13:0] f1_year_ff;
   logic [3:0]         f1_month_ff;
   logic [4:0]         f1_day_ff;
   logic [2:0]         f1_wd_ff;
   logic [5:0]         f1_week_ff;
   logic signed [13:0] f1_uyear_ff;
   logic [2:0]         f1_iwd_ff;
   logic [8:0]         f1_uord_ff;
   logic               f1_uleap_ff;
   logic               f1_uleap_prev_ff;

   logic               rsp_valid_ff;
   logic signed [13:0] rsp_year_ff;
   logic [3:0]         rsp_month_ff;
   logic [4:0]         rsp_day_ff;
   logic [2:0]         rsp_weekday_ff;
   logic [4:0]         rsp_hour_ff;
   logic [5:0]         rsp_minute_ff;
   logic [5:0]         rsp_second_ff;
   logic signed [13:0] rsp_wk_year_ff;
   logic [5:0]         rsp_wk_num_ff;
   logic [2:0]         rsp_wk_day_ff;

   logic [48:0]        ms_biased_in;
   logic [63:0]        ms_div_in [1:5];
   logic signed [16:0] tz_sec_in;
   logic [38:0]        utc_sec_in;
   logic [63:0]        hour_in;
   logic [2:0]         iwd_in;
   logic [8:0]         week_x_in;
   logic [63:0]        week_in;
   logic [63:0]        min_in;
   logic signed [13:0] wk_year_in;
   logic [5:0]         wk_num_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= '0;
      end else if (csr_write_enable) begin
         tz_ff <= csr_write_data;
      end
   end

   // ms / 1000 as (ms / 8) / 125 on the offset value
   assign ms_biased_in = 49'({~req_unix_ms[47], req_unix_ms[46:0]}) + MS_ROUND;

   for (genvar k = 1; k <= 5; k++) begin : g_ms_div
      localparam int unsigned NSTEP = (k == 5) ? 7 : 8;
      assign ms_div_in[k] = div_steps(24'(ms_r_ff[k-1]), 40'(ms_q_ff[k-1]), DIV_MS_8,
                                      39, NSTEP);
   end

   assign tz_sec_in  = 17'(tz_ff * 7'sd60);
   assign utc_sec_in = ms_q_ff[5] + SEC_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= 5; k++) begin
            ms_v_ff[k] <= 1'b0;
         end
         sec_v_ff     <= 1'b0;
         f1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         ms_v_ff[0] <= req_valid;
         for (int k = 1; k <= 5; k++) begin
            ms_v_ff[k] <= ms_v_ff[k-1];
         end
         sec_v_ff     <= ms_v_ff[5];
         f1_v_ff      <= loc_v;
         rsp_valid_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ms_r_ff[0] <= ms_biased_in[48:42];
         ms_q_ff[0] <= ms_biased_in[41:3];
         for (int k = 1; k <= 5; k++) begin
            ms_r_ff[k] <= ms_div_in[k][40 +: 7];
            ms_q_ff[k] <= ms_div_in[k][38:0];
         end
         utc_sec_ff <= utc_sec_in;
         loc_sec_ff <= utc_sec_in + 39'(tz_sec_in);
      end
   end

   u2c_days_to_date u_loc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sec_v_ff),
      .in_sec    (loc_sec_ff),
      .out_valid (loc_v),
      .out_date  (loc_date)
   );

   u2c_days_to_date u_utc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sec_v_ff),
      .in_sec    (utc_sec_ff),
      .out_valid (),
      .out_date  (utc_date)
   );

   always_comb begin
      hour_in   = div_steps(24'(loc_date.rem[16:5]), 40'(loc_date.rem[4:0]), DIV_HOUR, 5, 5);
      iwd_in    = utc_date.weekday + 3'd1;
      week_x_in = utc_date.ordinal - 9'(iwd_in) + 9'd10;
      week_in   = div_steps(24'(week_x_in[8:6]), 40'(week_x_in[5:0]), DIV_WEEK, 6, 6);
      min_in    = div_steps(24'(f1_rhour_ff[11:6]), 40'(f1_rhour_ff[5:0]), DIV_MIN, 6, 6);
   end

   // week 0 belongs to the last week of the previous ISO year; week 53 may
   // belong to week 1 of the next
   always_comb begin
      logic [2:0] wd31;
      logic [9:0] ndays;
      wd31  = f1_iwd_ff - f1_uord_ff[2:0];
      ndays = f1_uleap_ff ? 10'd366 : 10'd365;
      wk_year_in = f1_uyear_ff;
      wk_num_in  = f1_week_ff;
      if (f1_week_ff == 6'd0) begin
         wk_year_in = f1_uyear_ff - 14'sd1;
         wk_num_in  = ((wd31 == 3'd4) || (f1_uleap_prev_ff && (wd31 == 3'd5))) ? 6'd53
                                                                                : 6'd52;
      end else if (f1_week_ff > 6'd52) begin
         if ((ndays + 10'(f1_iwd_ff) - 10'(f1_uord_ff)) < 10'd4) begin
            wk_year_in = f1_uyear_ff + 14'sd1;
            wk_num_in  = 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_hour_ff       <= hour_in[4:0];
         f1_rhour_ff      <= hour_in[40 +: 12];
         f1_year_ff       <= loc_date.year;
         f1_month_ff      <= loc_date.month;
         f1_day_ff        <= loc_date.day;
         f1_wd_ff         <= loc_date.weekday;
         f1_week_ff       <= week_in[5:0];
         f1_uyear_ff      <= utc_date.year;
         f1_iwd_ff        <= iwd_in;
         f1_uord_ff       <= utc_date.ordinal;
         f1_uleap_ff      <= utc_date.leap;
         f1_uleap_prev_ff <= utc_date.leap_prev;

         rsp_year_ff    <= f1_year_ff;
         rsp_month_ff   <= f1_month_ff;
         rsp_day_ff     <= f1_day_ff;
         rsp_weekday_ff <= f1_wd_ff;
         rsp_hour_ff    <= f1_hour_ff;
         rsp_minute_ff  <= min_in[5:0];
         rsp_second_ff  <= min_in[40 +: 6];
         rsp_wk_year_ff <= wk_year_in;
         rsp_wk_num_ff  <= wk_num_in;
         rsp_wk_day_ff  <= f1_iwd_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_day_ff;
   assign rsp_weekday      = rsp_weekday_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_wk_year      = rsp_wk_year_ff;
   assign rsp_wk_num       = rsp_wk_num_ff;
   assign rsp_wk_day       = rsp_wk_day_ff;

endmodule
